// ===== rtl/core/rled_pkg.sv =====
// Types and constants shared by the RGB LED effect generator.
package rled_pkg;

    typedef enum logic [1:0] {
        MODE_NONE    = 2'd0,
        MODE_BREATHE = 2'd1,
        MODE_SEQ     = 2'd2,
        MODE_FAST    = 2'd3
    } led_mode_t;

    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_LED_MODE    = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TICK_DIVIDE = 1'd1;

    localparam logic [15:0] TICK_DIVIDE_RESET = 16'd50;

    localparam logic [7:0] LEVEL_MAX = 8'd255;
    localparam logic [7:0] LEVEL_MIN = 8'd0;

    localparam logic [2:0][7:0] BREATHE_TOP = {8'd252, 8'd253, 8'd255};
    localparam logic [2:0][7:0] BREATHE_BOT = {8'd3, 8'd2, 8'd0};

    localparam logic [7:0] SEQ_TOP  = 8'd251;
    localparam logic [7:0] SEQ_BOT  = 8'd3;
    localparam logic [7:0] SEQ_STEP = 8'd4;

    localparam logic [7:0] FAST_TOP  = 8'd224;
    localparam logic [7:0] FAST_BOT  = 8'd31;
    localparam logic [7:0] FAST_STEP = 8'd32;

    // colour orders of the sequential effect, by the order they route c1, c2, c3
    localparam logic [2:0] ORD_RGB = 3'd0;
    localparam logic [2:0] ORD_GRB = 3'd1;
    localparam logic [2:0] ORD_BGR = 3'd2;
    localparam logic [2:0] ORD_GBR = 3'd3;
    localparam logic [2:0] ORD_BRG = 3'd4;
    localparam logic [2:0] ORD_RBG = 3'd5;

    typedef struct packed {
        logic printing;
        logic paused;
    } tick_item_t;

    typedef struct packed {
        logic [7:0] red_duty;
        logic [7:0] green_duty;
        logic [7:0] blue_duty;
        logic       written;
    } duty_item_t;

endpackage

// ===== rtl/core/rgb_led_effect_generator.sv =====
// RGB LED effect generator: prescaled breathing, sequential and fast-blink duty effects.
//
// Usage:
//   tick channel (tick_valid, tick_stall, tick): one timer tick per item, with the
//   printing and paused flags. duty channel (duty_valid, duty_stall, duty): one item
//   per tick with the red, green and blue duties on the pins after that tick and a
//   flag that says whether the tick wrote them.
//   cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data): index 0 selects the
//   effect, index 1 sets the prescaler count. cfg_ready is always high; write only
//   while no tick is in flight.
// Throughput:
//   a tick updates all effect state together; its result is registered in the output
//   register, or in the skid register while held. One tick is taken every cycle while
//   tick_stall is low, set by the single state update ahead of the result register.
// Reset:
//   effect off, prescaler count 50, ramps at 255, duties 0, both channels empty.
// Stall:
//   a two-entry output stage (result register plus skid register) absorbs one extra
//   tick while duty_stall is high; tick_stall rises once the skid register fills.
module rgb_led_effect_generator (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 tick_valid,
    output logic                                 tick_stall,
    input  rled_pkg::tick_item_t                 tick,
    output logic                                 duty_valid,
    input  logic                                 duty_stall,
    output rled_pkg::duty_item_t                 duty,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rled_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [rled_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import rled_pkg::*;

    led_mode_t         led_mode_reg;
    logic [15:0]       tick_divide_reg;
    logic [15:0]       prescale_count_reg, prescale_count_next;
    logic [2:0][7:0]   ramp_level_reg, ramp_level_next;
    logic [2:0]        ramp_rising_reg, ramp_rising_next;
    logic [2:0][7:0]   seq_level_reg, seq_level_next;
    logic              seq_rising_reg, seq_rising_next;
    logic [2:0]        seq_order_reg, seq_order_next;
    logic [2:0][7:0]   pin_duty_reg, pin_duty_next;
    logic              wrote;
    logic              seq_done;

    logic              out_valid_reg;
    duty_item_t        out_item_reg;
    logic              skid_valid_reg;
    duty_item_t        skid_item_reg;
    duty_item_t        result;
    logic              tick_accept;
    logic              duty_take;

    assign cfg_ready   = 1'b1;
    assign tick_stall  = skid_valid_reg;
    assign tick_accept = tick_valid && !skid_valid_reg;
    assign duty_take   = out_valid_reg && !duty_stall;
    assign duty_valid  = out_valid_reg;
    assign duty        = out_item_reg;

    always_comb
    begin
        prescale_count_next = prescale_count_reg;
        ramp_level_next     = ramp_level_reg;
        ramp_rising_next    = ramp_rising_reg;
        seq_level_next      = seq_level_reg;
        seq_rising_next     = seq_rising_reg;
        seq_order_next      = seq_order_reg;
        pin_duty_next       = pin_duty_reg;
        wrote               = 1'b0;
        seq_done            = 1'b0;

        if (prescale_count_reg < tick_divide_reg)
        begin
            prescale_count_next = prescale_count_reg + 16'd1;
        end
        else
        begin
            prescale_count_next = '0;
            unique case (led_mode_reg)
                MODE_BREATHE:
                begin
                    if (tick.printing != tick.paused)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            if (ramp_rising_reg[i])
                            begin
                                if (ramp_level_reg[i] < BREATHE_TOP[i])
                                    ramp_level_next[i] = ramp_level_reg[i] + 8'(i + 1);
                                else
                                    ramp_rising_next[i] = 1'b0;
                            end
                            else
                            begin
                                if (ramp_level_reg[i] > BREATHE_BOT[i])
                                    ramp_level_next[i] = ramp_level_reg[i] - 8'(i + 1);
                                else
                                    ramp_rising_next[i] = 1'b1;
                            end
                        end
                        pin_duty_next = {ramp_level_next[0], ramp_level_next[1],
                                         ramp_level_next[2]};
                        wrote = 1'b1;
                    end
                    else
                    begin
                        ramp_level_next = {LEVEL_MAX, LEVEL_MAX, LEVEL_MAX};
                    end
                end
                MODE_SEQ:
                begin
                    if (seq_rising_reg)
                    begin
                        if (seq_level_reg[0] < SEQ_TOP)
                            seq_level_next[0] = seq_level_reg[0] + SEQ_STEP;
                        else if (seq_level_reg[1] < SEQ_TOP)
                            seq_level_next[1] = seq_level_reg[1] + SEQ_STEP;
                        else if (seq_level_reg[2] < SEQ_TOP)
                            seq_level_next[2] = seq_level_reg[2] + SEQ_STEP;
                        else
                            seq_done = 1'b1;
                    end
                    else
                    begin
                        if (seq_level_reg[0] > SEQ_BOT)
                            seq_level_next[0] = seq_level_reg[0] - SEQ_STEP;
                        else if (seq_level_reg[1] > SEQ_BOT)
                            seq_level_next[1] = seq_level_reg[1] - SEQ_STEP;
                        else if (seq_level_reg[2] > SEQ_BOT)
                            seq_level_next[2] = seq_level_reg[2] - SEQ_STEP;
                        else
                            seq_done = 1'b1;
                    end

                    if (seq_done)
                    begin
                        seq_rising_next = !seq_rising_reg;
                        if (seq_order_reg <= ORD_BGR)
                            seq_order_next = seq_order_reg + 3'd1;
                        else if (seq_order_reg == ORD_RBG)
                            seq_order_next = ORD_RGB;
                    end

                    wrote = 1'b1;
                    case (seq_order_next)
                        ORD_RGB: pin_duty_next = {seq_level_next[2], seq_level_next[1],
                                                  seq_level_next[0]};
                        ORD_GRB: pin_duty_next = {seq_level_next[2], seq_level_next[0],
                                                  seq_level_next[1]};
                        ORD_BGR: pin_duty_next = {seq_level_next[0], seq_level_next[1],
                                                  seq_level_next[2]};
                        ORD_GBR: pin_duty_next = {seq_level_next[0], seq_level_next[2],
                                                  seq_level_next[1]};
                        ORD_BRG: pin_duty_next = {seq_level_next[1], seq_level_next[0],
                                                  seq_level_next[2]};
                        ORD_RBG: pin_duty_next = {seq_level_next[1], seq_level_next[2],
                                                  seq_level_next[0]};
                        default: wrote = 1'b0;
                    endcase
                end
                MODE_FAST:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        if (ramp_rising_reg[i])
                        begin
                            if (ramp_level_reg[i] < FAST_TOP)
                            begin
                                ramp_level_next[i] = ramp_level_reg[i] + FAST_STEP;
                            end
                            else
                            begin
                                ramp_rising_next[i] = 1'b0;
                                ramp_level_next[i]  = LEVEL_MAX;
                            end
                        end
                        else
                        begin
                            if (ramp_level_reg[i] > FAST_BOT)
                            begin
                                ramp_level_next[i] = ramp_level_reg[i] - FAST_STEP;
                            end
                            else
                            begin
                                ramp_rising_next[i] = 1'b1;
                                ramp_level_next[i]  = LEVEL_MIN;
                            end
                        end
                    end
                    pin_duty_next = {ramp_level_next[0], ramp_level_next[1],
                                     ramp_level_next[2]};
                    wrote = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        result.red_duty   = pin_duty_next[0];
        result.green_duty = pin_duty_next[1];
        result.blue_duty  = pin_duty_next[2];
        result.written    = wrote;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_mode_reg    <= MODE_NONE;
            tick_divide_reg <= TICK_DIVIDE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_LED_MODE:    led_mode_reg    <= led_mode_t'(cfg_data[1:0]);
                CFG_TICK_DIVIDE: tick_divide_reg <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_count_reg <= '0;
            ramp_level_reg     <= {LEVEL_MAX, LEVEL_MAX, LEVEL_MAX};
            ramp_rising_reg    <= '0;
            seq_level_reg      <= {LEVEL_MAX, LEVEL_MAX, LEVEL_MAX};
            seq_rising_reg     <= 1'b0;
            seq_order_reg      <= ORD_RGB;
            pin_duty_reg       <= '0;
        end
        else if (tick_accept)
        begin
            prescale_count_reg <= prescale_count_next;
            ramp_level_reg     <= ramp_level_next;
            ramp_rising_reg    <= ramp_rising_next;
            seq_level_reg      <= seq_level_next;
            seq_rising_reg     <= seq_rising_next;
            seq_order_reg      <= seq_order_next;
            pin_duty_reg       <= pin_duty_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (duty_take)
                skid_valid_reg <= 1'b0;
        end
        else if (tick_accept)
        begin
            if (out_valid_reg && !duty_take)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (duty_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (duty_take)
                out_item_reg <= skid_item_reg;
        end
        else if (tick_accept)
        begin
            if (out_valid_reg && !duty_take)
                skid_item_reg <= result;
            else
                out_item_reg <= result;
        end
    end

endmodule
